// ----- design/fedl_pkg.sv -----
// Shared constants and types for the feedback echo delay line.
package fedl_pkg;

    // Depth of the echo store and the width of its addresses.
    localparam int DELAY_DEPTH = 131072;
    localparam int ADDR_W      = $clog2(DELAY_DEPTH);

    // Store entries are signed Q15.2.
    localparam int STORE_W = 18;

    // Sample and configuration widths.
    localparam int SAMPLE_W = 16;
    localparam int FRAMES_W = 17;
    localparam int DECAY_W  = 16;
    localparam int CHAN_W   = 4;
    localparam int CFG_IDX_W = 2;

    // Product of delay frames and channel count.
    localparam int DPROD_W = FRAMES_W + CHAN_W;

    // Decay limits and mix coefficients, all Q0.16, and the delay floor in frames.
    localparam logic [DECAY_W-1:0]  DECAY_MAX   = 16'd58982;
    localparam logic [DECAY_W-1:0]  DECAY_FLOOR = 16'd655;
    localparam logic [FRAMES_W-1:0] DELAY_FLOOR = 17'd100;
    localparam logic [16:0]         COEF_DRY    = 17'd45875;
    localparam logic [16:0]         COEF_WET    = 17'd19661;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_FRAMES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_LEVEL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = 36;
    localparam int MUL_B_W = 17;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Request to the shared multiplier.
    typedef struct packed {
        logic                      en;
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } t_mul_req;

endpackage

// ----- design/fedl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module fedl_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 131072
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/fedl_mul.sv -----
// Shared signed multiplier with a registered product.
module fedl_mul (
    input  logic                              i_clk,
    input  fedl_pkg::t_mul_req                i_req,
    output logic signed [fedl_pkg::MUL_P_W-1:0] o_prod
);
    import fedl_pkg::*;

    logic signed [MUL_P_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= $signed(i_req.a) * $signed(i_req.b);
        end
    end

    assign o_prod = r_prod;

endmodule

// ----- design/feedback_echo_delay_line.sv -----
// Top level of the feedback echo delay line: sequencer, store and output register.
//
// One signed 16-bit interleaved audio sample enters per beat on the slave stream
// (i_s_tvalid, o_s_tready, i_s_tdata) and one mixed sample leaves per beat on the
// master stream (o_m_tvalid, i_m_tready, o_m_tdata). The configuration channel
// (i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data) writes delay_frames (0),
// decay_level (1) and channel_count (2); it is always ready and should only be
// used while no sample is in flight.
// An echo sample runs from accept through an address step, the registered store
// read, three passes through the one shared multiplier (decay, dry gain, wet
// gain) and a step that loads the output register, and only then can the next
// sample be accepted. A pass-through sample (short delay or tiny decay) goes
// from the address step straight to the output step and leaves the store alone.
// Reset clears the write index, the fill marker and the configuration to
// delay 0, decay 0 and one channel. Entries not yet written since reset read
// as zero by comparing against the write index, so no clearing pass is needed.
// If the receiver stalls, the finished sample waits in the output register and
// the sequencer holds in its last state, so no input is taken meanwhile.
module feedback_echo_delay_line (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave stream, tdata: sample_in [15:0].
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,
    // Master stream, tdata: sample_out [15:0].
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data
);
    import fedl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADDR,
        S_READ,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_OUT
    } t_state;

    // Control state.
    t_state              r_state, n_state;
    logic [FRAMES_W-1:0] r_frames, n_frames;
    logic [DECAY_W-1:0]  r_decay_cfg, n_decay_cfg;
    logic [CHAN_W-1:0]   r_chan, n_chan;
    logic [ADDR_W-1:0]   r_wi, n_wi;
    logic                r_wrapped, n_wrapped;
    logic                r_out_valid, n_out_valid;

    // Payload.
    logic signed [SAMPLE_W-1:0] r_x, n_x;
    logic [DECAY_W-1:0]         r_d, n_d;
    logic                       r_ok, n_ok;
    logic signed [34:0]         r_wet, n_wet;
    logic signed [31:0]         r_dry, n_dry;
    logic [SAMPLE_W-1:0]        r_y, n_y;
    logic [SAMPLE_W-1:0]        r_out_data, n_out_data;

    // Datapath signals.
    logic [DPROD_W-1:0]        dprod;
    logic [ADDR_W-1:0]         dly;
    logic [ADDR_W:0]           rd_wide;
    logic [ADDR_W-1:0]         rd_addr;
    logic [DECAY_W-1:0]        d_clamped;
    logic                      pass;
    logic [STORE_W-1:0]        ram_rdata;
    logic                      ram_we;
    logic [STORE_W-1:0]        st_val;
    logic signed [35:0]        st_sum;
    logic signed [51:0]        y_sum;
    logic signed [MUL_P_W-1:0] mul_prod;
    t_mul_req                  mul_req;
    logic                      in_fire;
    logic                      out_free;

    assign in_fire  = i_s_tvalid && o_s_tready;
    assign out_free = !r_out_valid || i_m_tready;

    // Effective delay: frames times channels, held between 1 and depth minus one.
    assign dprod = {{CHAN_W{1'b0}}, r_frames} * {{FRAMES_W{1'b0}}, r_chan};
    always_comb begin
        if (32'(dprod) > 32'(DELAY_DEPTH - 1)) begin
            dly = ADDR_W'(DELAY_DEPTH - 1);
        end else if (dprod == '0) begin
            dly = ADDR_W'(1);
        end else begin
            dly = dprod[ADDR_W-1:0];
        end
    end

    // Read address lies dly entries behind the write index, with wrap.
    always_comb begin
        if ({1'b0, r_wi} >= {1'b0, dly}) begin
            rd_wide = {1'b0, r_wi} - {1'b0, dly};
        end else begin
            rd_wide = {1'b0, r_wi} + (ADDR_W+1)'(DELAY_DEPTH) - {1'b0, dly};
        end
    end
    assign rd_addr = rd_wide[ADDR_W-1:0];

    assign d_clamped = (r_decay_cfg > DECAY_MAX) ? DECAY_MAX : r_decay_cfg;
    assign pass      = (r_frames <= DELAY_FLOOR) || (d_clamped <= DECAY_FLOOR);

    // Stored value: (x + wet/2^18) * 2 in Q15.2, rounded half up, saturated.
    assign st_sum = ($signed({{20{r_x[SAMPLE_W-1]}}, r_x}) <<< 18)
                  + $signed({r_wet[34], r_wet}) + 36'sd65536;
    always_comb begin
        if (st_sum[35] != st_sum[34]) begin
            st_val = st_sum[35] ? {1'b1, {(STORE_W-1){1'b0}}} : {1'b0, {(STORE_W-1){1'b1}}};
        end else begin
            st_val = st_sum[34:17];
        end
    end

    // Output sum: dry term plus wet term in units of 2^-34, with rounding.
    assign y_sum = ($signed({{20{r_dry[31]}}, r_dry}) <<< 18)
                 + $signed(mul_prod[51:0]) + (52'sd1 <<< 33);

    assign ram_we = (r_state == S_MUL2);

    fedl_ram #(
        .WIDTH(STORE_W),
        .DEPTH(DELAY_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_wi),
        .i_wdata(st_val),
        .i_raddr(rd_addr),
        .o_rdata(ram_rdata)
    );

    fedl_mul u_mul (
        .i_clk (i_clk),
        .i_req (mul_req),
        .o_prod(mul_prod)
    );

    // Sequencer and next-state logic.
    always_comb begin
        n_state     = r_state;
        n_frames    = r_frames;
        n_decay_cfg = r_decay_cfg;
        n_chan      = r_chan;
        n_wi        = r_wi;
        n_wrapped   = r_wrapped;
        n_out_valid = r_out_valid;
        n_x         = r_x;
        n_d         = r_d;
        n_ok        = r_ok;
        n_wet       = r_wet;
        n_dry       = r_dry;
        n_y         = r_y;
        n_out_data  = r_out_data;
        mul_req     = '0;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DELAY_FRAMES:  n_frames    = i_cfg_data[FRAMES_W-1:0];
                CFG_DECAY_LEVEL:   n_decay_cfg = i_cfg_data[DECAY_W-1:0];
                CFG_CHANNEL_COUNT: n_chan      = i_cfg_data[CHAN_W-1:0];
                default: ;
            endcase
        end

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_x     = $signed(i_s_tdata);
                    n_state = S_ADDR;
                end
            end
            S_ADDR: begin
                // The store latches rd_addr at this edge.
                n_d  = d_clamped;
                n_ok = r_wrapped || (rd_addr < r_wi);
                if (pass) begin
                    n_y     = r_x;
                    n_state = S_OUT;
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                mul_req.en = 1'b1;
                mul_req.a  = r_ok ? MUL_A_W'($signed(ram_rdata)) : '0;
                mul_req.b  = $signed({1'b0, r_d});
                n_state    = S_MUL1;
            end
            S_MUL1: begin
                n_wet      = mul_prod[34:0];
                mul_req.en = 1'b1;
                mul_req.a  = MUL_A_W'(r_x);
                mul_req.b  = $signed(COEF_DRY);
                n_state    = S_MUL2;
            end
            S_MUL2: begin
                n_dry      = mul_prod[31:0];
                mul_req.en = 1'b1;
                mul_req.a  = MUL_A_W'(r_wet);
                mul_req.b  = $signed(COEF_WET);
                n_state    = S_MUL3;
            end
            S_MUL3: begin
                if (y_sum[51:49] != {3{y_sum[49]}}) begin
                    n_y = y_sum[51] ? 16'h8000 : 16'h7FFF;
                end else begin
                    n_y = y_sum[49:34];
                end
                if (r_wi == ADDR_W'(DELAY_DEPTH - 1)) begin
                    n_wi      = '0;
                    n_wrapped = 1'b1;
                end else begin
                    n_wi = r_wi + ADDR_W'(1);
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_y;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_d        <= n_d;
        r_ok       <= n_ok;
        r_wet      <= n_wet;
        r_dry      <= n_dry;
        r_y        <= n_y;
        r_out_data <= n_out_data;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_frames    <= '0;
            r_decay_cfg <= '0;
            r_chan      <= CHAN_W'(1);
            r_wi        <= '0;
            r_wrapped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_frames    <= n_frames;
            r_decay_cfg <= n_decay_cfg;
            r_chan      <= n_chan;
            r_wi        <= n_wi;
            r_wrapped   <= n_wrapped;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;
    assign o_cfg_ready = 1'b1;

`ifndef SYNTHESIS
    // A sample is never taken in two consecutive cycles.
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !o_s_tready)
        else $error("second sample accepted while the first is in work");

    // The write index never leaves the store.
    a_wi_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_wi) <= 32'(DELAY_DEPTH - 1))
        else $error("write index beyond store depth");

    // The store is written only after the decay product has been formed.
    a_write_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> $past(r_state == S_MUL1))
        else $error("store written out of sequence");

    // The write index moves only on the final multiply step.
    a_wi_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_MUL3) |=> $stable(r_wi))
        else $error("write index moved outside the final step");
`endif

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the feedback echo delay line stream block.

import fedl_pkg::*;

// Tracks the echo store, write index and registers of the block, works out the
// mixed sample that every accepted input beat must produce, and checks the output
// beats against those samples in order.
class echo_mix_checker;
    int          echo_store [DELAY_DEPTH];
    int          write_pos;
    logic [16:0] frames;
    logic [15:0] decay;
    logic [3:0]  chans;
    logic [15:0] mix_due [$];
    int          mismatches;

    function new();
        write_pos  = 0;
        frames     = '0;
        decay      = '0;
        chans      = 4'd1;
        mismatches = 0;
    endfunction

    // Registers keep only their own width, and unknown indexes are dropped.
    function void write_register(logic [1:0] index, logic [16:0] value);
        case (index)
            CFG_DELAY_FRAMES:  frames = value[16:0];
            CFG_DECAY_LEVEL:   decay  = value[15:0];
            CFG_CHANNEL_COUNT: chans  = value[3:0];
            default: ;
        endcase
    endfunction

    // Works out the output for one accepted sample and updates the echo state.
    function void predict_mix(logic signed [15:0] x);
        logic [15:0] d;
        longint      dly;
        longint      xl;
        longint      wet;
        longint      st;
        longint      y;
        int          rd_pos;

        d  = (decay > DECAY_MAX) ? DECAY_MAX : decay;
        xl = longint'(x);
        // Short delay or negligible decay: the sample passes through untouched.
        if (frames <= DELAY_FLOOR || d <= DECAY_FLOOR) begin
            mix_due.push_back(x);
            return;
        end
        dly = longint'(frames) * longint'(chans);
        if (dly > DELAY_DEPTH - 1) dly = DELAY_DEPTH - 1;
        if (dly < 1) dly = 1;
        rd_pos = int'((longint'(write_pos) + DELAY_DEPTH - dly) % DELAY_DEPTH);
        // Q15.2 entry times Q0.16 decay gives the wet value scaled by 2^-18.
        wet = longint'(echo_store[rd_pos]) * longint'(d);
        st  = (xl * 262144 + wet + (longint'(1) << 16)) >>> 17;
        if (st > 131071) st = 131071;
        if (st < -131072) st = -131072;
        echo_store[write_pos] = int'(st);
        y = (xl * longint'(COEF_DRY) * 262144 + wet * longint'(COEF_WET)
             + (longint'(1) << 33)) >>> 34;
        if (y > 32767) y = 32767;
        if (y < -32768) y = -32768;
        mix_due.push_back(y[15:0]);
        write_pos = (write_pos + 1) % DELAY_DEPTH;
    endfunction

    function void check_mix(logic [15:0] got);
        logic [15:0] want;

        if (mix_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected output beat: sample_out=%0d", $signed(got));
            return;
        end
        want = mix_due.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("sample_out mismatch: expected %0d, got %0d",
                         $signed(want), $signed(got));
        end
    endfunction

    function int pending();
        return mix_due.size();
    endfunction
endclass

module testbench;
    // Index that the block does not decode; writes to it must change nothing.
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    // Slave stream, tdata: sample_in [15:0].
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [15:0] i_s_tdata;
    // Master stream, tdata: sample_out [15:0].
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [16:0] i_cfg_data;

    echo_mix_checker mix_chk;
    int              samples_sent;
    bit              sender_idles;
    bit              receiver_stalls;

    feedback_echo_delay_line dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs a handshake. The limit lies far beyond
    // what a correct run needs, so this leaves a wide margin.
    initial begin
        #(20 * 600000);
        $display("feedback_echo_delay_line verification failed");
        $finish;
    end

    // All driving happens on the falling edge; handshakes are sampled on the
    // rising edge, where the block's registered outputs still hold their old value.
    task automatic write_cfg(input logic [1:0] index, input logic [16:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        mix_chk.write_register(index, value);
        @(negedge i_clk);
    endtask

    // Writes all three registers back to back, then drops the valid.
    task automatic configure(input logic [16:0] frames_val, input logic [16:0] decay_val,
                             input logic [16:0] chan_val);
        write_cfg(CFG_DELAY_FRAMES, frames_val);
        write_cfg(CFG_DECAY_LEVEL, decay_val);
        write_cfg(CFG_CHANNEL_COUNT, chan_val);
        i_cfg_valid <= 1'b0;
    endtask

    // Sends one sample beat. The valid is lowered only when a gap is drawn, so it
    // stays high across back-to-back beats. Returns at the falling edge after the
    // beat was taken.
    task automatic send_sample(input logic [15:0] sample);
        int gap;

        gap = sender_idles ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= sample;
        do @(posedge i_clk); while (!o_s_tready);
        mix_chk.predict_mix(sample);
        samples_sent++;
        @(negedge i_clk);
    endtask

    // Lets the block finish: waits until every predicted beat has come out, then
    // idles on so the sequencer is back at rest.
    task automatic drain_block();
        do @(negedge i_clk); while (mix_chk.pending() > 0);
        repeat (8) @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'($signed($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    // Receiver: stalls a random number of cycles before every beat when stalling
    // is on, and checks each beat that it takes.
    initial begin
        int stall;

        @(posedge i_rst_n);
        forever begin
            stall = receiver_stalls ? $urandom_range(0, 11) : 0;
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            mix_chk.check_mix(o_m_tdata);
            @(negedge i_clk);
        end
    end

    initial begin
        logic [16:0] frames_val;
        logic [16:0] decay_val;
        logic [16:0] chan_val;
        int          beats;

        mix_chk         = new();
        samples_sent    = 0;
        sender_idles    = 1'b1;
        receiver_stalls = 1'b1;
        i_rst_n         = 1'b0;
        i_s_tvalid      = 1'b0;
        i_s_tdata       = '0;
        i_m_tready      = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // With the reset settings every sample passes straight through.
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'h0001);
        i_s_tvalid <= 1'b0;
        drain_block();

        // Decay written above its range with a stray upper bit, and channel count
        // zero with upper bits set: the delay collapses to one sample, so full scale
        // input feeds back on every beat.
        configure(17'd101, 17'h1FFFF, 17'h1FFF0);
        repeat (4) send_sample(16'h7FFF);
        repeat (4) send_sample(16'h8000);
        i_s_tvalid <= 1'b0;
        drain_block();

        // A delay of exactly 100 frames is still a pass-through.
        configure(17'd100, 17'(DECAY_MAX), 17'd1);
        send_sample(16'd1234);
        send_sample(-16'sd1234);
        i_s_tvalid <= 1'b0;
        drain_block();

        // Decay right at the floor passes through, one step above it echoes.
        configure(17'd101, 17'(DECAY_FLOOR), 17'd1);
        send_sample(16'h4000);
        send_sample(16'hC000);
        i_s_tvalid <= 1'b0;
        drain_block();
        configure(17'd101, 17'(DECAY_FLOOR) + 17'd1, 17'd2);
        send_sample(16'h7FFF);
        send_sample(16'h8001);
        i_s_tvalid <= 1'b0;
        drain_block();

        // Longest delay with eight channels is clamped to the store depth minus one.
        configure(17'h1FFFF, 17'(DECAY_MAX), 17'd8);
        repeat (3) send_sample(pick_sample());
        i_s_tvalid <= 1'b0;
        drain_block();

        // A write to an undecoded index must leave every setting alone.
        write_cfg(CFG_UNUSED, 17'h1FFFF);
        i_cfg_valid <= 1'b0;
        send_sample(16'h1357);
        send_sample(16'hECA9);
        i_s_tvalid <= 1'b0;
        drain_block();

        // Random phases. Most use delays just past the floor on one or two channels
        // so the feedback path fills and the echo comes back within the run.
        while (samples_sent < 420) begin
            case ($urandom_range(0, 9))
                0:       frames_val = 17'($urandom_range(0, 100));
                1:       frames_val = $urandom_range(0, 1) ? 17'h1FFFF : 17'($urandom);
                default: frames_val = 17'($urandom_range(101, 180));
            endcase
            case ($urandom_range(0, 9))
                0:       decay_val = 17'($urandom_range(0, 655));
                1:       decay_val = 17'($urandom_range(58982, 65535));
                default: decay_val = 17'($urandom_range(656, 58982));
            endcase
            if ($urandom_range(0, 3) == 0)
                decay_val[16] = 1'b1;
            if ($urandom_range(0, 4) == 0)
                chan_val = 17'($urandom);
            else
                chan_val = 17'($urandom_range(1, 2));
            configure(frames_val, decay_val, chan_val);
            if ($urandom_range(0, 7) == 0) begin
                @(negedge i_clk);
                write_cfg(CFG_UNUSED, 17'($urandom));
                i_cfg_valid <= 1'b0;
            end
            sender_idles    = ($urandom_range(0, 3) != 0);
            receiver_stalls = ($urandom_range(0, 3) != 0);
            beats = $urandom_range(10, 60);
            repeat (beats) begin
                send_sample(pick_sample());
                // Now and then hold off until the block has delivered everything.
                if ($urandom_range(0, 39) == 0) begin
                    i_s_tvalid <= 1'b0;
                    do @(negedge i_clk); while (mix_chk.pending() > 0);
                end
            end
            i_s_tvalid <= 1'b0;
            drain_block();
        end

        // drain_block already waited for the queue to empty; keep the clock running
        // so that any beat the block emits unasked is still caught.
        repeat (12) @(posedge i_clk);
        if (mix_chk.mismatches == 0 && mix_chk.pending() == 0) begin
            $display("feedback_echo_delay_line verification clean");
        end else begin
            $display("feedback_echo_delay_line verification failed");
        end
        $finish;
    end
endmodule

// ----- feedback_echo_delay_line.f -----
design/fedl_pkg.sv
design/fedl_ram.sv
design/fedl_mul.sv
design/feedback_echo_delay_line.sv
tb/testbench.sv
